### sv/pid_pkg.sv
// Shared types, widths and constants of the clamped-integral PID controller.
// No dependencies; every other file imports this package.
package pid_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_WIDTH     = 16;
    localparam int TIME_WIDTH     = 32;
    localparam int INT_WIDTH      = FRACTION_BITS + 2;
    localparam int CFG_IDX_WIDTH  = 8;
    localparam int MS_PER_SECOND  = 1000;

    // Serial multiplier operands: A is the wide magnitude, B is shifted out bit by bit.
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Serial divider operands.
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    // Signed accumulator for the sum of the three gain terms.
    localparam int ACC_W = 52;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SETPOINT = 8'd0,
        CFG_GAIN_P   = 8'd1,
        CFG_GAIN_I   = 8'd2,
        CFG_GAIN_D   = 8'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_DIV_I,
        S_MUL_D,
        S_DIV_D,
        S_MUL_P,
        S_MUL_GI,
        S_MUL_GD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage

### sv/pid_if.sv
// Valid/ready channel interfaces of the PID controller: input, result and config.
// Depends on pid_pkg for field widths.
interface pid_in_if import pid_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] measured_angle;
    logic        [TIME_WIDTH-1:0]  time_ms;
    modport source (output valid, measured_angle, time_ms, input ready);
    modport sink   (input valid, measured_angle, time_ms, output ready);
endinterface

interface pid_out_if import pid_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] drive;
    logic signed [VALUE_WIDTH-1:0] error_value;
    logic signed [INT_WIDTH-1:0]   integral_value;
    logic                          zero_interval;
    modport source (output valid, drive, error_value, integral_value, zero_interval,
                    input ready);
    modport sink   (input valid, drive, error_value, integral_value, zero_interval,
                    output ready);
endinterface

interface pid_cfg_if import pid_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [VALUE_WIDTH-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/pid_controller_clamped_integral.sv
// PID controller with clamped integral, top level: sequencer, state and config.
// Depends on pid_pkg, pid_if, pid_mul and pid_div.
//
// One input beat (measured angle, millisecond time) yields one result beat (drive,
// error, integral, zero-interval flag); one item is worked on at a time. The error
// is setpoint minus measurement, saturated to 32 bits; dt is the time difference
// modulo 2^32. All arithmetic runs through one bit-serial multiplier and one
// bit-serial restoring divider; when dt is zero the derivative multiply and divide
// and the derivative gain multiply are skipped. The integral adds |err|*dt/1000 with
// the sign of err and is clamped to +-1.0 (Q2.16); the derivative is
// (err - previous err)*1000/dt, truncated toward zero. Each term is scaled by its
// Q8.8 gain and the sum is saturated to 32 bits. The config channel is always ready;
// write it only while the block is idle. Writes to an index above 3 are dropped.
module pid_controller_clamped_integral import pid_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pid_in_if.sink    in_ch,
    pid_out_if.source out_ch,
    pid_cfg_if.sink   cfg_ch
);
    localparam int DMAG_W = 43;
    localparam int IABS_W = FRACTION_BITS + 1;
    localparam int QI_W   = FRACTION_BITS + 3;
    localparam int SUM_W  = FRACTION_BITS + 4;

    localparam logic [QI_W-1:0] INC_MAX = QI_W'(1) << (FRACTION_BITS + 2);
    localparam logic signed [SUM_W-1:0] ONE_POS = SUM_W'(1) << FRACTION_BITS;
    localparam logic signed [SUM_W-1:0] ONE_NEG = -(SUM_W'(1) << FRACTION_BITS);
    localparam logic signed [VALUE_WIDTH-1:0] DRV_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] DRV_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Configuration registers
    logic signed [VALUE_WIDTH-1:0] setpoint_reg;
    logic [GAIN_WIDTH-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;

    // Controller state kept across items
    logic signed [INT_WIDTH-1:0]   int_reg, int_next;
    logic signed [VALUE_WIDTH-1:0] prev_err_reg;
    logic [TIME_WIDTH-1:0]         prev_time_reg;

    // Per-item working registers
    state_t                        state_reg, state_next;
    logic                          launch_reg, launch_next;
    logic signed [VALUE_WIDTH-1:0] err_reg;
    logic                          errneg_reg;
    logic [VALUE_WIDTH-1:0]        erra_reg;
    logic [TIME_WIDTH-1:0]         dt_reg;
    logic                          zero_reg;
    logic                          dneg_reg;
    logic [VALUE_WIDTH:0]          dabs_reg;
    logic [DMAG_W-1:0]             dmag_reg, dmag_next;
    logic                          intneg_reg, intneg_next;
    logic [IABS_W-1:0]             intabs_reg, intabs_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;

    // Result register
    logic                          out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] drive_reg, err_out_reg;
    logic signed [INT_WIDTH-1:0]   int_out_reg;
    logic                          zero_out_reg;

    // Arithmetic units
    unit_ctl_t              mul_ctl, div_ctl;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic                   mul_done;
    logic [MUL_P_W-1:0]     mul_prod;
    logic [DIV_N_W-1:0]     div_n;
    logic [DIV_D_W-1:0]     div_d;
    logic                   div_done;
    logic [DIV_N_W-1:0]     div_quo;

    // Combinational helpers
    logic                          in_fire;
    logic                          out_load;
    logic signed [VALUE_WIDTH:0]   err_wide;
    logic signed [VALUE_WIDTH-1:0] err_sat;
    logic signed [VALUE_WIDTH:0]   dd_wide;
    logic [QI_W-1:0]               qi;
    logic signed [SUM_W-1:0]       int_sum;
    logic signed [SUM_W-1:0]       int_clamped;
    logic signed [ACC_W-1:0]       term;
    logic                          term_neg;
    logic [ACC_W-VALUE_WIDTH:0]    acc_top;
    logic signed [VALUE_WIDTH-1:0] drive_sat;
    logic                          start;

    pid_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    pid_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (div_ctl),
        .n      (div_n),
        .d      (div_d),
        .done   (div_done),
        .quo    (div_quo)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    // Error and its difference, computed at the input beat
    always_comb
    begin
        err_wide = {setpoint_reg[VALUE_WIDTH-1], setpoint_reg}
                 - {in_ch.measured_angle[VALUE_WIDTH-1], in_ch.measured_angle};
        if (err_wide[VALUE_WIDTH] != err_wide[VALUE_WIDTH-1])
            err_sat = err_wide[VALUE_WIDTH] ? DRV_MIN : DRV_MAX;
        else
            err_sat = err_wide[VALUE_WIDTH-1:0];
        dd_wide = {err_sat[VALUE_WIDTH-1], err_sat}
                - {prev_err_reg[VALUE_WIDTH-1], prev_err_reg};
    end

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            gain_p_reg   <= GAIN_WIDTH'(256);
            gain_i_reg   <= GAIN_WIDTH'(13);
            gain_d_reg   <= GAIN_WIDTH'(64);
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                CFG_SETPOINT: setpoint_reg <= cfg_ch.data;
                CFG_GAIN_P:   gain_p_reg   <= cfg_ch.data[GAIN_WIDTH-1:0];
                CFG_GAIN_I:   gain_i_reg   <= cfg_ch.data[GAIN_WIDTH-1:0];
                CFG_GAIN_D:   gain_d_reg   <= cfg_ch.data[GAIN_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            int_reg       <= '0;
            prev_err_reg  <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            int_reg    <= int_next;
            if (in_fire)
            begin
                prev_err_reg  <= err_sat;
                prev_time_reg <= in_ch.time_ms;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            err_reg    <= err_sat;
            errneg_reg <= err_sat[VALUE_WIDTH-1];
            erra_reg   <= err_sat[VALUE_WIDTH-1] ? VALUE_WIDTH'(-err_sat)
                                                 : VALUE_WIDTH'(err_sat);
            dt_reg     <= in_ch.time_ms - prev_time_reg;
            zero_reg   <= (in_ch.time_ms == prev_time_reg);
            dneg_reg   <= dd_wide[VALUE_WIDTH];
            dabs_reg   <= dd_wide[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-dd_wide)
                                              : (VALUE_WIDTH+1)'(dd_wide);
        end
        dmag_reg   <= dmag_next;
        intneg_reg <= intneg_next;
        intabs_reg <= intabs_next;
        acc_reg    <= acc_next;
        if (out_load)
        begin
            drive_reg    <= drive_sat;
            err_out_reg  <= err_reg;
            int_out_reg  <= int_reg;
            zero_out_reg <= zero_reg;
        end
    end

    // Integral update, clamped to +-1.0
    always_comb
    begin
        qi = (div_quo > DIV_N_W'(INC_MAX)) ? INC_MAX : div_quo[QI_W-1:0];
        int_sum = SUM_W'(int_reg)
                + (errneg_reg ? -$signed({1'b0, qi}) : $signed({1'b0, qi}));
        if (int_sum > ONE_POS)
            int_clamped = ONE_POS;
        else if (int_sum < ONE_NEG)
            int_clamped = ONE_NEG;
        else
            int_clamped = int_sum;
    end

    // Gain term from the multiplier, and the saturated drive
    always_comb
    begin
        term = $signed(mul_prod[ACC_W+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS]);
        case (state_reg)
            S_MUL_P:  term_neg = errneg_reg;
            S_MUL_GI: term_neg = intneg_reg;
            S_MUL_GD: term_neg = dneg_reg;
            default:  term_neg = 1'b0;
        endcase
        acc_top = acc_reg[ACC_W-1:VALUE_WIDTH-1];
        if ((&acc_top) || !(|acc_top))
            drive_sat = acc_reg[VALUE_WIDTH-1:0];
        else
            drive_sat = acc_reg[ACC_W-1] ? DRV_MIN : DRV_MAX;
    end

    // Operand selection for the shared units
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_I:
            begin
                mul_a = MUL_A_W'(erra_reg);
                mul_b = dt_reg;
            end
            S_MUL_D:
            begin
                mul_a = MUL_A_W'(dabs_reg);
                mul_b = MUL_B_W'(MS_PER_SECOND);
            end
            S_MUL_P:
            begin
                mul_a = MUL_A_W'(erra_reg);
                mul_b = MUL_B_W'(gain_p_reg);
            end
            S_MUL_GI:
            begin
                mul_a = MUL_A_W'(intabs_reg);
                mul_b = MUL_B_W'(gain_i_reg);
            end
            S_MUL_GD:
            begin
                mul_a = MUL_A_W'(dmag_reg);
                mul_b = MUL_B_W'(gain_d_reg);
            end
            default: ;
        endcase
        div_n = mul_prod[DIV_N_W-1:0];
        div_d = (state_reg == S_DIV_D) ? dt_reg : DIV_D_W'(MS_PER_SECOND);
    end

    // Sequencer: each working state launches its unit once and waits for done
    always_comb
    begin
        state_next    = state_reg;
        launch_next   = launch_reg;
        int_next      = int_reg;
        dmag_next     = dmag_reg;
        intneg_next   = intneg_reg;
        intabs_next   = intabs_reg;
        acc_next      = acc_reg;
        start         = (state_reg != S_IDLE) && (state_reg != S_OUT) && !launch_reg;
        mul_ctl.start = 1'b0;
        mul_ctl.done  = mul_done;
        div_ctl.start = 1'b0;
        div_ctl.done  = div_done;
        if (start)
            launch_next = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next   = '0;
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                mul_ctl.start = start;
                if (mul_done)
                begin
                    launch_next = 1'b0;
                    state_next  = S_DIV_I;
                end
            end
            S_DIV_I:
            begin
                div_ctl.start = start;
                if (div_done)
                begin
                    launch_next = 1'b0;
                    int_next    = int_clamped[INT_WIDTH-1:0];
                    intneg_next = int_clamped[SUM_W-1];
                    intabs_next = int_clamped[SUM_W-1] ? IABS_W'(-int_clamped)
                                                       : IABS_W'(int_clamped);
                    state_next  = zero_reg ? S_MUL_P : S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                mul_ctl.start = start;
                if (mul_done)
                begin
                    launch_next = 1'b0;
                    state_next  = S_DIV_D;
                end
            end
            S_DIV_D:
            begin
                div_ctl.start = start;
                if (div_done)
                begin
                    launch_next = 1'b0;
                    dmag_next   = div_quo[DMAG_W-1:0];
                    state_next  = S_MUL_P;
                end
            end
            S_MUL_P, S_MUL_GI, S_MUL_GD:
            begin
                mul_ctl.start = start;
                if (mul_done)
                begin
                    launch_next = 1'b0;
                    acc_next    = term_neg ? acc_reg - term : acc_reg + term;
                    if (state_reg == S_MUL_P)
                        state_next = S_MUL_GI;
                    else if (state_reg == S_MUL_GI && !zero_reg)
                        state_next = S_MUL_GD;
                    else
                        state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.drive          = drive_reg;
    assign out_ch.error_value    = err_out_reg;
    assign out_ch.integral_value = int_out_reg;
    assign out_ch.zero_interval  = zero_out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("controller stayed idle after an input beat");

    a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (int_reg <= ONE_POS[INT_WIDTH-1:0] || int_reg[INT_WIDTH-1])
        && (int_reg >= ONE_NEG[INT_WIDTH-1:0] || !int_reg[INT_WIDTH-1]))
        else $error("integral outside +-1.0");

    a_no_deriv_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_D || state_reg == S_DIV_D || state_reg == S_MUL_GD)
        |-> !zero_reg)
        else $error("derivative path entered with zero interval");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result beat raised outside the output state");

endmodule

### sv/pid_mul.sv
// Bit-serial shift-add multiplier: one bit of B per cycle, unsigned.
// Depends on pid_pkg.
module pid_mul import pid_pkg::*; #(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  unit_ctl_t        ctl_in,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic             done,
    output logic [A_W+B_W-1:0] prod
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [A_W:0]     sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    always_comb
    begin
        sum       = {1'b0, acc_reg[P_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl_in.start)
        begin
            acc_next  = {{A_W{1'b0}}, b};
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the partial product, shift one bit of B out
            acc_next = {sum, acc_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### sv/pid_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// Depends on pid_pkg.
module pid_div import pid_pkg::*; #(
    parameter int N_W = DIV_N_W,
    parameter int D_W = DIV_D_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  unit_ctl_t      ctl_in,
    input  logic [N_W-1:0] n,
    input  logic [D_W-1:0] d,
    output logic           done,
    output logic [N_W-1:0] quo
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   nq_reg, nq_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    always_comb
    begin
        trial     = {rem_reg, nq_reg[N_W-1]};
        diff      = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl_in.start)
        begin
            nq_next   = n;
            rem_next  = '0;
            d_next    = d;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // bring down one dividend bit, subtract where it fits
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            nq_next  = {nq_reg[N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule
